// ----- rtl/core/rdsd_pkg.sv -----
// shared types, constants and character mapping for the rds group decoder
package rdsd_pkg;

   typedef logic [7:0]  char_type;
   typedef logic [15:0] pair_type;
   typedef logic [1:0]  opcode_type;
   typedef logic [1:0]  grade_type;

   // text store geometry
   localparam int PS_LEN     = 8;
   localparam int RT_LEN     = 64;
   localparam int PS_ROWS    = PS_LEN / 2;
   localparam int RT_ROWS    = RT_LEN / 4;
   localparam int PS_ROW_W   = $clog2(PS_ROWS);
   localparam int RT_ROW_W   = $clog2(RT_ROWS);

   // operation codes
   localparam opcode_type OP_DECODE  = 2'd0;
   localparam opcode_type OP_READ_PS = 2'd1;
   localparam opcode_type OP_READ_RT = 2'd2;
   localparam opcode_type OP_NOP     = 2'd3;

   // block quality and group types
   localparam grade_type  GRADE_BAD  = 2'd3;
   localparam logic [3:0] GROUP_BASIC = 4'd0;
   localparam logic [3:0] GROUP_RTEXT = 4'd2;

   // character codes
   localparam char_type CHAR_SPACE   = 8'h20;
   localparam char_type CHAR_TILDE   = 8'h7E;
   localparam char_type CHAR_QMARK   = 8'h3F;
   localparam char_type CHAR_LOW_A   = 8'h61;
   localparam char_type CHAR_LOW_O   = 8'h6F;
   localparam char_type CHAR_LOW_U   = 8'h75;
   localparam char_type CHAR_NUL     = 8'h00;
   localparam char_type RAW_A_UMLAUT = 8'h8E;
   localparam char_type RAW_O_UMLAUT = 8'h99;
   localparam char_type RAW_U_UMLAUT = 8'h9A;
   localparam char_type RAW_CR       = 8'h0D;

   localparam pair_type PAIR_SPACES  = {CHAR_SPACE, CHAR_SPACE};

   // raw rds byte to ascii
   function automatic char_type map_char(input char_type raw);
      char_type res;
      priority if (raw < CHAR_SPACE) begin
         res = CHAR_SPACE;
      end else if (raw <= CHAR_TILDE) begin
         res = raw;
      end else if (raw == RAW_A_UMLAUT) begin
         res = CHAR_LOW_A;
      end else if (raw == RAW_O_UMLAUT) begin
         res = CHAR_LOW_O;
      end else if (raw == RAW_U_UMLAUT) begin
         res = CHAR_LOW_U;
      end else begin
         res = CHAR_QMARK;
      end
      return res;
   endfunction

   // radiotext maps carriage return to nul as end-of-text marker
   function automatic char_type map_rt_char(input char_type raw);
      char_type res;
      if (raw == RAW_CR) begin
         res = CHAR_NUL;
      end else begin
         res = map_char(raw);
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/rdsd_ram.sv -----
// generic single write port ram with registered read
module rdsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-cycle write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/rds_group_decoder.sv -----
// rds group decoder: status registers, service name and radiotext stores
// a request beat passes the decode stage register, then the response register
// throughput: one beat per cycle while the response side does not stall; the single
//    decode stage takes a new beat whenever its result moves into the response register
// reset: control and status clear synchronously; text stores read as spaces
//    through per-row valid bits, with no clearing pass
module rds_group_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  logic [15:0]          req_block_a,
   input  logic [15:0]          req_block_b,
   input  logic [15:0]          req_block_c,
   input  logic [15:0]          req_block_d,
   input  logic [7:0]           req_block_errors,
   input  logic [5:0]           req_read_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_group_accepted,
   output logic [15:0]          rsp_program_id,
   output logic                 rsp_traffic_program,
   output logic [4:0]           rsp_program_type,
   output logic                 rsp_traffic_announce,
   output logic                 rsp_music_speech,
   output logic                 rsp_group_seen,
   output logic                 rsp_ps_changed,
   output logic                 rsp_rt_ab_flag,
   output logic                 rsp_rt_toggled,
   output rdsd_pkg::char_type   rsp_text_char
);

   import rdsd_pkg::*;

   // handshake
   logic req_accept;
   logic s1_adv;

   // decode stage registers
   logic        s1_valid_ff, s1_valid_in;
   opcode_type  s1_opcode_ff;
   logic [15:0] s1_block_a_ff, s1_block_b_ff, s1_block_c_ff, s1_block_d_ff;
   logic [7:0]  s1_errors_ff;
   logic [5:0]  s1_index_ff;

   // store bypass registers
   logic     ps_byp_ff, ps_byp_in;
   pair_type ps_byp_data_ff;
   logic     rt_lo_byp_ff, rt_lo_byp_in;
   pair_type rt_lo_byp_data_ff;
   logic     rt_hi_byp_ff, rt_hi_byp_in;
   pair_type rt_hi_byp_data_ff;

   // row valid bits
   logic [PS_ROWS-1:0] ps_vld_ff, ps_vld_in;
   logic [RT_ROWS-1:0] rt_lo_vld_ff, rt_lo_vld_in;
   logic [RT_ROWS-1:0] rt_hi_vld_ff, rt_hi_vld_in;

   // status registers
   logic [15:0] pi_ff, pi_in;
   logic        tp_ff, tp_in;
   logic [4:0]  pty_ff, pty_in;
   logic        ta_ff, ta_in;
   logic        ms_ff, ms_in;
   logic        seen_ff, seen_in;
   logic        ps_chg_ff, ps_chg_in;
   logic        ab_ff, ab_in;
   logic        rt_chg_ff, rt_chg_in;

   // response registers
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_acc_ff;
   char_type rsp_char_ff;
   logic     rsp_acc_in;
   char_type rsp_char_in;

   // decode terms
   logic ok_a, ok_b, ok_c, ok_d;
   logic grp_ok, grp0, grp2;
   logic [3:0] grp_type;
   logic       grp_ver;
   char_type   ps_hi, ps_lo;
   pair_type   ps_new, ps_cur, ps_ram_data;
   logic [PS_ROW_W-1:0] ps_raddr, ps_s1_row;
   logic                ps_we;
   logic [RT_ROW_W-1:0] rt_row, rt_raddr, rt_s1_row;
   logic                rt_lo_we, rt_hi_we;
   pair_type            rt_lo_wdata, rt_hi_wdata, rt_c_pair, rt_d_pair;
   pair_type            rt_lo_ram_data, rt_hi_ram_data, rt_lo_cur, rt_hi_cur, rt_sel;

   // handshake and stage occupancy
   assign s1_adv      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !s1_adv;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // capture request beat
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_opcode_ff  <= req_opcode;
         s1_block_a_ff <= req_block_a;
         s1_block_b_ff <= req_block_b;
         s1_block_c_ff <= req_block_c;
         s1_block_d_ff <= req_block_d;
         s1_errors_ff  <= req_block_errors;
         s1_index_ff   <= req_read_index;
      end
   end

   // block grades and group classification
   assign ok_a     = s1_errors_ff[1:0] != GRADE_BAD;
   assign ok_b     = s1_errors_ff[3:2] != GRADE_BAD;
   assign ok_c     = s1_errors_ff[5:4] != GRADE_BAD;
   assign ok_d     = s1_errors_ff[7:6] != GRADE_BAD;
   assign grp_type = s1_block_b_ff[15:12];
   assign grp_ver  = s1_block_b_ff[11];
   assign grp_ok   = (s1_opcode_ff == OP_DECODE) && ok_a && ok_b;
   assign grp0     = grp_ok && (grp_type == GROUP_BASIC);
   assign grp2     = grp_ok && (grp_type == GROUP_RTEXT) && ok_c && ok_d;

   // service name: compare the addressed pair, write only on a difference
   assign ps_hi     = map_char(s1_block_d_ff[15:8]);
   assign ps_lo     = map_char(s1_block_d_ff[7:0]);
   assign ps_new    = {ps_hi, ps_lo};
   assign ps_s1_row = (s1_opcode_ff == OP_READ_PS) ? s1_index_ff[2:1]
                                                   : s1_block_b_ff[1:0];
   assign ps_cur    = ps_byp_ff ? ps_byp_data_ff
                                : (ps_vld_ff[ps_s1_row] ? ps_ram_data : PAIR_SPACES);
   assign ps_we     = s1_adv && grp0 && ok_d && (ps_cur != ps_new);
   assign ps_raddr  = (req_opcode == OP_READ_PS) ? req_read_index[2:1]
                                                 : req_block_b[1:0];

   rdsd_ram #(
      .WIDTH (16),
      .DEPTH (PS_ROWS)
   ) u_ps_ram (
      .clock   (clock),
      .wr_en   (ps_we),
      .wr_addr (s1_block_b_ff[1:0]),
      .wr_data (ps_new),
      .rd_en   (req_accept),
      .rd_addr (ps_raddr),
      .rd_data (ps_ram_data)
   );

   // radiotext: rows of four chars split in a low and a high pair
   assign rt_c_pair   = {map_rt_char(s1_block_c_ff[15:8]), map_rt_char(s1_block_c_ff[7:0])};
   assign rt_d_pair   = {map_rt_char(s1_block_d_ff[15:8]), map_rt_char(s1_block_d_ff[7:0])};
   assign rt_row      = grp_ver ? {1'b0, s1_block_b_ff[3:1]} : s1_block_b_ff[3:0];
   assign rt_lo_we    = s1_adv && grp2 && (!grp_ver || !s1_block_b_ff[0]);
   assign rt_hi_we    = s1_adv && grp2 && (!grp_ver || s1_block_b_ff[0]);
   assign rt_lo_wdata = grp_ver ? rt_d_pair : rt_c_pair;
   assign rt_hi_wdata = rt_d_pair;
   assign rt_raddr    = req_read_index[5:2];
   assign rt_s1_row   = s1_index_ff[5:2];

   rdsd_ram #(
      .WIDTH (16),
      .DEPTH (RT_ROWS)
   ) u_rt_lo_ram (
      .clock   (clock),
      .wr_en   (rt_lo_we),
      .wr_addr (rt_row),
      .wr_data (rt_lo_wdata),
      .rd_en   (req_accept),
      .rd_addr (rt_raddr),
      .rd_data (rt_lo_ram_data)
   );

   rdsd_ram #(
      .WIDTH (16),
      .DEPTH (RT_ROWS)
   ) u_rt_hi_ram (
      .clock   (clock),
      .wr_en   (rt_hi_we),
      .wr_addr (rt_row),
      .wr_data (rt_hi_wdata),
      .rd_en   (req_accept),
      .rd_addr (rt_raddr),
      .rd_data (rt_hi_ram_data)
   );

   assign rt_lo_cur = rt_lo_byp_ff ? rt_lo_byp_data_ff
                                   : (rt_lo_vld_ff[rt_s1_row] ? rt_lo_ram_data : PAIR_SPACES);
   assign rt_hi_cur = rt_hi_byp_ff ? rt_hi_byp_data_ff
                                   : (rt_hi_vld_ff[rt_s1_row] ? rt_hi_ram_data : PAIR_SPACES);
   assign rt_sel    = s1_index_ff[1] ? rt_hi_cur : rt_lo_cur;

   // forward a write that lands on the row read at the same edge
   assign ps_byp_in    = ps_we && (s1_block_b_ff[1:0] == ps_raddr);
   assign rt_lo_byp_in = rt_lo_we && (rt_row == rt_raddr);
   assign rt_hi_byp_in = rt_hi_we && (rt_row == rt_raddr);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ps_byp_ff         <= ps_byp_in;
         ps_byp_data_ff    <= ps_new;
         rt_lo_byp_ff      <= rt_lo_byp_in;
         rt_lo_byp_data_ff <= rt_lo_wdata;
         rt_hi_byp_ff      <= rt_hi_byp_in;
         rt_hi_byp_data_ff <= rt_hi_wdata;
      end
   end

   // row valid bits
   always_comb begin
      ps_vld_in    = ps_vld_ff;
      rt_lo_vld_in = rt_lo_vld_ff;
      rt_hi_vld_in = rt_hi_vld_ff;
      if (ps_we) begin
         ps_vld_in[s1_block_b_ff[1:0]] = 1'b1;
      end
      if (rt_lo_we) begin
         rt_lo_vld_in[rt_row] = 1'b1;
      end
      if (rt_hi_we) begin
         rt_hi_vld_in[rt_row] = 1'b1;
      end
   end

   // status next values
   always_comb begin
      pi_in     = pi_ff;
      tp_in     = tp_ff;
      pty_in    = pty_ff;
      ta_in     = ta_ff;
      ms_in     = ms_ff;
      seen_in   = seen_ff;
      ps_chg_in = ps_chg_ff || ps_we;
      ab_in     = ab_ff;
      rt_chg_in = rt_chg_ff;
      if (s1_adv && grp_ok) begin
         pi_in   = s1_block_a_ff;
         tp_in   = s1_block_b_ff[10];
         pty_in  = s1_block_b_ff[9:5];
         seen_in = 1'b1;
      end
      if (s1_adv && grp0) begin
         ta_in = s1_block_b_ff[4];
         ms_in = s1_block_b_ff[3];
      end
      if (s1_adv && grp2 && (s1_block_b_ff[4] != ab_ff)) begin
         ab_in     = s1_block_b_ff[4];
         rt_chg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pi_ff        <= '0;
         tp_ff        <= 1'b0;
         pty_ff       <= '0;
         ta_ff        <= 1'b0;
         ms_ff        <= 1'b0;
         seen_ff      <= 1'b0;
         ps_chg_ff    <= 1'b0;
         ab_ff        <= 1'b0;
         rt_chg_ff    <= 1'b0;
         ps_vld_ff    <= '0;
         rt_lo_vld_ff <= '0;
         rt_hi_vld_ff <= '0;
      end else begin
         pi_ff        <= pi_in;
         tp_ff        <= tp_in;
         pty_ff       <= pty_in;
         ta_ff        <= ta_in;
         ms_ff        <= ms_in;
         seen_ff      <= seen_in;
         ps_chg_ff    <= ps_chg_in;
         ab_ff        <= ab_in;
         rt_chg_ff    <= rt_chg_in;
         ps_vld_ff    <= ps_vld_in;
         rt_lo_vld_ff <= rt_lo_vld_in;
         rt_hi_vld_ff <= rt_hi_vld_in;
      end
   end

   // text read result
   always_comb begin
      rsp_char_in = CHAR_NUL;
      unique case (s1_opcode_ff)
         OP_READ_PS: begin
            if (s1_index_ff[5:3] == 3'd0) begin
               rsp_char_in = s1_index_ff[0] ? ps_cur[7:0] : ps_cur[15:8];
            end
         end
         OP_READ_RT: begin
            rsp_char_in = s1_index_ff[0] ? rt_sel[7:0] : rt_sel[15:8];
         end
         OP_DECODE, OP_NOP: begin
            rsp_char_in = CHAR_NUL;
         end
         default: begin
            rsp_char_in = CHAR_NUL;
         end
      endcase
   end

   assign rsp_acc_in   = grp_ok;
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_acc_ff  <= rsp_acc_in;
         rsp_char_ff <= rsp_char_in;
      end
   end

   // status registers change only as a beat enters the response register
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_group_accepted   = rsp_acc_ff;
   assign rsp_text_char        = rsp_char_ff;
   assign rsp_program_id       = pi_ff;
   assign rsp_traffic_program  = tp_ff;
   assign rsp_program_type     = pty_ff;
   assign rsp_traffic_announce = ta_ff;
   assign rsp_music_speech     = ms_ff;
   assign rsp_group_seen       = seen_ff;
   assign rsp_ps_changed       = ps_chg_ff;
   assign rsp_rt_ab_flag       = ab_ff;
   assign rsp_rt_toggled       = rt_chg_ff;

`ifndef SYNTHESIS
   // a service name write shows up as a changed flag on its beat
   a_ps_write_flags: assert property (@(posedge clock) disable iff (reset)
      ps_we |=> (rsp_valid && rsp_ps_changed && rsp_group_accepted))
      else $error("service name write without changed flag");

   // a radiotext write comes only from an accepted group
   a_rt_write_accepted: assert property (@(posedge clock) disable iff (reset)
      (rt_lo_we || rt_hi_we) |=> (rsp_valid && rsp_group_accepted))
      else $error("radiotext write from a rejected group");

   // accepted groups never carry a read character
   a_accept_no_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_group_accepted) |-> (rsp_text_char == CHAR_NUL))
      else $error("character on a decode beat");

   // sticky flags stay set
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_group_seen && rsp_ps_changed) |=> (rsp_group_seen && rsp_ps_changed))
      else $error("sticky flag cleared");

   // the decode stage never drops a beat
   a_stage_adv: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> s1_valid_ff)
      else $error("held decode beat lost");
`endif

endmodule

// ----- dv/rds_group_decoder_tb.sv -----
// self-checking testbench for the rds group decoder: directed and random beats
module rds_group_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rdsd_pkg::*;

   localparam int RANDOM_BEATS = 1950;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      opcode_type  opcode;
      logic [15:0] block_a;
      logic [15:0] block_b;
      logic [15:0] block_c;
      logic [15:0] block_d;
      logic [7:0]  block_errors;
      logic [5:0]  read_index;
   } rds_req_type;

   typedef struct packed {
      logic        group_accepted;
      logic [15:0] program_id;
      logic        traffic_program;
      logic [4:0]  program_type;
      logic        traffic_announce;
      logic        music_speech;
      logic        group_seen;
      logic        ps_changed;
      logic        rt_ab_flag;
      logic        rt_toggled;
      char_type    text_char;
   } rds_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [1:0]        req_opcode       = OP_NOP;
   logic [15:0]       req_block_a      = '0;
   logic [15:0]       req_block_b      = '0;
   logic [15:0]       req_block_c      = '0;
   logic [15:0]       req_block_d      = '0;
   logic [7:0]        req_block_errors = '0;
   logic [5:0]        req_read_index   = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic              rsp_group_accepted;
   logic [15:0]       rsp_program_id;
   logic              rsp_traffic_program;
   logic [4:0]        rsp_program_type;
   logic              rsp_traffic_announce;
   logic              rsp_music_speech;
   logic              rsp_group_seen;
   logic              rsp_ps_changed;
   logic              rsp_rt_ab_flag;
   logic              rsp_rt_toggled;
   char_type          rsp_text_char;

   // predicted decoder state
   logic [15:0] pi_state;
   logic        tp_state;
   logic [4:0]  pty_state;
   logic        ta_state;
   logic        ms_state;
   logic        seen_state;
   logic        ps_dirty;
   logic        ab_state;
   logic        rt_dirty;
   char_type    ps_text [PS_LEN];
   char_type    rt_text [RT_LEN];

   rds_status_type pending_status [$];

   int n_sent       = 0;
   int n_checked    = 0;
   int n_failures   = 0;
   int n_groups_ok  = 0;
   int n_reads      = 0;
   int burst_left   = 0;
   int idle_cycles  = 0;
   int stall_mode   = 0;
   int stall_tick   = 0;

   rds_group_decoder uut (.*);

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // raw rds byte to the ascii code the stores hold
   function automatic char_type rds_to_ascii(input char_type raw);
      if (raw < CHAR_SPACE) return CHAR_SPACE;
      if (raw <= CHAR_TILDE) return raw;
      case (raw)
         RAW_A_UMLAUT: return CHAR_LOW_A;
         RAW_O_UMLAUT: return CHAR_LOW_O;
         RAW_U_UMLAUT: return CHAR_LOW_U;
         default:      return CHAR_QMARK;
      endcase
   endfunction

   function automatic char_type rt_to_ascii(input char_type raw);
      return (raw == RAW_CR) ? CHAR_NUL : rds_to_ascii(raw);
   endfunction

   function automatic void clear_decoder_state();
      pi_state   = '0;
      tp_state   = 1'b0;
      pty_state  = '0;
      ta_state   = 1'b0;
      ms_state   = 1'b0;
      seen_state = 1'b0;
      ps_dirty   = 1'b0;
      ab_state   = 1'b0;
      rt_dirty   = 1'b0;
      foreach (ps_text[i]) ps_text[i] = CHAR_SPACE;
      foreach (rt_text[i]) rt_text[i] = CHAR_SPACE;
   endfunction

   // apply one request beat to the predicted state, return the status it reports
   function automatic rds_status_type decoder_status_after(input rds_req_type r);
      rds_status_type s;
      logic        accepted;
      char_type    hi_ch;
      char_type    lo_ch;
      int          pos;
      accepted = 1'b0;
      s.text_char = CHAR_NUL;
      case (r.opcode)
         OP_DECODE: begin
            if (r.block_errors[1:0] != GRADE_BAD && r.block_errors[3:2] != GRADE_BAD) begin
               accepted   = 1'b1;
               pi_state   = r.block_a;
               tp_state   = r.block_b[10];
               pty_state  = r.block_b[9:5];
               seen_state = 1'b1;
               if (r.block_b[15:12] == GROUP_BASIC) begin
                  ta_state = r.block_b[4];
                  ms_state = r.block_b[3];
                  // service name pair, written only when it differs
                  if (r.block_errors[7:6] != GRADE_BAD) begin
                     hi_ch = rds_to_ascii(r.block_d[15:8]);
                     lo_ch = rds_to_ascii(r.block_d[7:0]);
                     pos   = r.block_b[1:0] * 2;
                     if (ps_text[pos] != hi_ch || ps_text[pos + 1] != lo_ch) begin
                        ps_text[pos]     = hi_ch;
                        ps_text[pos + 1] = lo_ch;
                        ps_dirty         = 1'b1;
                     end
                  end
               end else if (r.block_b[15:12] == GROUP_RTEXT &&
                            r.block_errors[5:4] != GRADE_BAD &&
                            r.block_errors[7:6] != GRADE_BAD) begin
                  // radiotext: version b carries two chars, version a four
                  if (r.block_b[11]) begin
                     pos = r.block_b[3:0] * 2;
                     rt_text[pos]     = rt_to_ascii(r.block_d[15:8]);
                     rt_text[pos + 1] = rt_to_ascii(r.block_d[7:0]);
                  end else begin
                     pos = r.block_b[3:0] * 4;
                     rt_text[pos]     = rt_to_ascii(r.block_c[15:8]);
                     rt_text[pos + 1] = rt_to_ascii(r.block_c[7:0]);
                     rt_text[pos + 2] = rt_to_ascii(r.block_d[15:8]);
                     rt_text[pos + 3] = rt_to_ascii(r.block_d[7:0]);
                  end
                  if (r.block_b[4] != ab_state) begin
                     ab_state = r.block_b[4];
                     rt_dirty = 1'b1;
                  end
               end
            end
         end
         OP_READ_PS: begin
            if (r.read_index < PS_LEN) s.text_char = ps_text[r.read_index];
         end
         OP_READ_RT: begin
            s.text_char = rt_text[r.read_index];
         end
         default: ;
      endcase
      s.group_accepted   = accepted;
      s.program_id       = pi_state;
      s.traffic_program  = tp_state;
      s.program_type     = pty_state;
      s.traffic_announce = ta_state;
      s.music_speech     = ms_state;
      s.group_seen       = seen_state;
      s.ps_changed       = ps_dirty;
      s.rt_ab_flag       = ab_state;
      s.rt_toggled       = rt_dirty;
      return s;
   endfunction

   function automatic logic [15:0] make_block_b(input logic [3:0] grp, input logic ver,
                                                input logic tp, input logic [4:0] pty,
                                                input logic flag, input logic [3:0] low);
      return {grp, ver, tp, pty, flag, low};
   endfunction

   function automatic rds_req_type group_beat(input logic [15:0] a, input logic [15:0] b,
                                              input logic [15:0] c, input logic [15:0] d,
                                              input logic [7:0] errs);
      rds_req_type r;
      r.opcode       = OP_DECODE;
      r.block_a      = a;
      r.block_b      = b;
      r.block_c      = c;
      r.block_d      = d;
      r.block_errors = errs;
      r.read_index   = 6'($urandom);
      return r;
   endfunction

   // read beats carry junk in the block fields, which must be ignored
   function automatic rds_req_type read_beat(input opcode_type op, input logic [5:0] idx);
      rds_req_type r;
      r.opcode       = op;
      r.block_a      = 16'($urandom);
      r.block_b      = 16'($urandom);
      r.block_c      = 16'($urandom);
      r.block_d      = 16'($urandom);
      r.block_errors = 8'($urandom);
      r.read_index   = idx;
      return r;
   endfunction

   // raw byte biased toward control codes, carriage return and umlauts
   function automatic char_type pick_raw_char();
      case ($urandom_range(0, 5))
         0:       return char_type'($urandom_range(0, 31));
         1:       return RAW_CR;
         2: begin
            case ($urandom_range(0, 2))
               0:       return RAW_A_UMLAUT;
               1:       return RAW_O_UMLAUT;
               default: return RAW_U_UMLAUT;
            endcase
         end
         3:       return char_type'($urandom_range(0, 255));
         default: return char_type'($urandom_range(32, 126));
      endcase
   endfunction

   function automatic logic [1:0] good_grade();
      return 2'($urandom_range(0, 2));
   endfunction

   // send one request beat; the sender runs in bursts with gaps between them
   task automatic send_beat(input rds_req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 250)
                                                 : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_opcode       <= r.opcode;
      req_block_a      <= r.block_a;
      req_block_b      <= r.block_b;
      req_block_c      <= r.block_c;
      req_block_d      <= r.block_d;
      req_block_errors <= r.block_errors;
      req_read_index   <= r.read_index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_status.push_back(decoder_status_after(r));
      n_sent++;
      if (r.opcode == OP_DECODE && pending_status[$].group_accepted) n_groups_ok++;
      if (r.opcode == OP_READ_PS || r.opcode == OP_READ_RT) n_reads++;
   endtask

   // status after reset, reads inside and past the stores, no operation
   task automatic test_reset_values();
      send_beat(read_beat(OP_READ_PS, 6'd0));
      send_beat(read_beat(OP_READ_PS, 6'd7));
      send_beat(read_beat(OP_READ_PS, 6'd8));
      send_beat(read_beat(OP_READ_PS, 6'd63));
      send_beat(read_beat(OP_READ_RT, 6'd63));
      send_beat(read_beat(OP_NOP, 6'd0));
   endtask

   // groups are dropped when block a or b is uncorrectable
   task automatic test_block_grades();
      send_beat(group_beat(16'hFFFF, 16'h0418, 16'h4142, 16'h4344, 8'h03));
      send_beat(group_beat(16'hFFFF, 16'h0418, 16'h4142, 16'h4344, 8'h0C));
      // other group type with every grade at its worst usable value
      send_beat(group_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hAA));
   endtask

   // group 0: ta, ms and the service name pair, with and without a change
   task automatic test_service_name();
      logic [15:0] b0;
      b0 = make_block_b(GROUP_BASIC, 1'b0, 1'b1, 5'd31, 1'b1, 4'hB);
      send_beat(group_beat(16'h0000, b0, 16'h0000, {RAW_A_UMLAUT, RAW_CR}, 8'h00));
      send_beat(group_beat(16'h1234, b0, 16'h0000, {RAW_A_UMLAUT, RAW_CR}, 8'h00));
      // bad block d keeps the name, still takes ta and ms
      send_beat(group_beat(16'hC0DE, make_block_b(GROUP_BASIC, 1'b1, 1'b0, 5'd0, 1'b0,
                                                   4'h0),
                           16'hFFFF, 16'h5858, 8'hC0));
      send_beat(read_beat(OP_READ_PS, 6'd6));
      send_beat(read_beat(OP_READ_PS, 6'd7));
      send_beat(read_beat(OP_READ_PS, 6'd0));
   endtask

   // group 2a and 2b text, carriage return, a toggle flip and a bad block c
   task automatic test_radiotext();
      send_beat(group_beat(16'h5A5A, make_block_b(GROUP_RTEXT, 1'b0, 1'b0, 5'd3, 1'b1, 4'hF),
                           {RAW_O_UMLAUT, RAW_U_UMLAUT}, {RAW_CR, 8'hFF}, 8'h00));
      send_beat(group_beat(16'h5A5A, make_block_b(GROUP_RTEXT, 1'b1, 1'b1, 5'd3, 1'b1, 4'hF),
                           16'h0000, 16'h4100, 8'h55));
      send_beat(group_beat(16'h5A5A, make_block_b(GROUP_RTEXT, 1'b1, 1'b1, 5'd3, 1'b0, 4'h0),
                           16'h0000, 16'h4242, 8'h30));
      send_beat(read_beat(OP_READ_RT, 6'd60));
      send_beat(read_beat(OP_READ_RT, 6'd62));
      send_beat(read_beat(OP_READ_RT, 6'd30));
      send_beat(read_beat(OP_READ_RT, 6'd31));
   endtask

   // mostly well-formed group 0 and 2 traffic with random content, plus noise
   task automatic test_random_traffic();
      rds_req_type r;
      logic [15:0] b;
      logic [15:0] d;
      logic [1:0]  g_c;
      logic [1:0]  g_d;
      int          sel;
      int          slot;
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 35) begin
            b = make_block_b(GROUP_BASIC, 1'($urandom), 1'($urandom), 5'($urandom),
                             1'($urandom), 4'($urandom));
            slot = b[1:0] * 2;
            if ($urandom_range(0, 9) < 3) d = {ps_text[slot], ps_text[slot + 1]};
            else d = {pick_raw_char(), pick_raw_char()};
            g_d = ($urandom_range(0, 6) == 0) ? GRADE_BAD : good_grade();
            r = group_beat(16'($urandom), b, 16'($urandom), d,
                           {g_d, 2'($urandom), good_grade(), good_grade()});
         end else if (sel < 60) begin
            b = make_block_b(GROUP_RTEXT, 1'($urandom), 1'($urandom), 5'($urandom),
                             ($urandom_range(0, 4) == 0) ? ~ab_state : ab_state,
                             4'($urandom));
            g_c = ($urandom_range(0, 9) == 0) ? GRADE_BAD : good_grade();
            g_d = ($urandom_range(0, 9) == 0) ? GRADE_BAD : good_grade();
            r = group_beat(16'($urandom), b, {pick_raw_char(), pick_raw_char()},
                           {pick_raw_char(), pick_raw_char()},
                           {g_d, g_c, good_grade(), good_grade()});
         end else if (sel < 70) begin
            r = read_beat(OP_READ_PS, ($urandom_range(0, 3) == 0) ? 6'($urandom)
                                                                  : 6'($urandom_range(0, 7)));
         end else if (sel < 80) begin
            r = read_beat(OP_READ_RT, 6'($urandom));
         end else if (sel < 95) begin
            r = read_beat(opcode_type'($urandom_range(0, 3)), 6'($urandom));
         end else begin
            // group 0 or 2 with one block forced uncorrectable
            b = make_block_b($urandom_range(0, 1) ? GROUP_RTEXT : GROUP_BASIC, 1'($urandom),
                             1'($urandom), 5'($urandom), 1'($urandom), 4'($urandom));
            r = group_beat(16'($urandom), b, 16'($urandom), 16'($urandom), 8'($urandom));
            r.block_errors[2 * $urandom_range(0, 3) +: 2] = GRADE_BAD;
         end
         send_beat(r);
      end
   endtask

   // response stall: a mode picked at random, from none to heavy
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_tick = stall_tick + 1;
         if (stall_tick % 100 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= (stall_tick % 7 < 3);
         endcase
      end
   end

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         n_failures++;
      end
   endfunction

   // compare each response beat with the oldest predicted status
   always @(posedge clock) begin : rsp_check
      rds_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            $error("response beat with no request outstanding");
            n_failures++;
         end else begin
            want = pending_status.pop_front();
            n_checked++;
            check_field("group_accepted", want.group_accepted, rsp_group_accepted);
            check_field("program_id", want.program_id, rsp_program_id);
            check_field("traffic_program", want.traffic_program, rsp_traffic_program);
            check_field("program_type", want.program_type, rsp_program_type);
            check_field("traffic_announce", want.traffic_announce, rsp_traffic_announce);
            check_field("music_speech", want.music_speech, rsp_music_speech);
            check_field("group_seen", want.group_seen, rsp_group_seen);
            check_field("ps_changed", want.ps_changed, rsp_ps_changed);
            check_field("rt_ab_flag", want.rt_ab_flag, rsp_rt_ab_flag);
            check_field("rt_toggled", want.rt_toggled, rsp_rt_toggled);
            check_field("text_char", want.text_char, rsp_text_char);
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("** rds_group_decoder: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_decoder_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_block_grades();
      test_service_name();
      test_radiotext();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_status.size() != 0) begin
         $error("%0d predicted responses never arrived", pending_status.size());
         n_failures++;
      end
      $display("sent %0d request beats: %0d groups accepted, %0d text reads",
               n_sent, n_groups_ok, n_reads);
      $display("checked %0d response beats field by field, %0d mismatches",
               n_checked, n_failures);
      if (n_failures == 0) begin
         $display("** rds_group_decoder: PASSED **");
      end else begin
         $display("** rds_group_decoder: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/rdsd_pkg.sv
rtl/core/rdsd_ram.sv
rtl/core/rds_group_decoder.sv
dv/rds_group_decoder_tb.sv
